/* hw/rtl/rec_pkg.sv */
package rec_pkg;

	// default width of the modular tick counter
	localparam int TimeWidthDefault = 32;

	// rotation codes
	localparam logic [1:0] ROT_NONE = 2'd0;
	localparam logic [1:0] ROT_CW   = 2'd1;
	localparam logic [1:0] ROT_CCW  = 2'd2;

	// click codes
	localparam logic [1:0] CLICK_NONE   = 2'd0;
	localparam logic [1:0] CLICK_SINGLE = 2'd1;
	localparam logic [1:0] CLICK_DOUBLE = 2'd2;

	// register indexes
	localparam logic REG_DEBOUNCE     = 1'b0;
	localparam logic REG_DOUBLE_CLICK = 1'b1;

	localparam int AddrWidth = 3;
	localparam logic [15:0] DebounceReset    = 16'd50;
	localparam logic [15:0] DoubleClickReset = 16'd300;

	// click counter saturation value
	localparam logic [1:0] ClickMax = 2'd2;

	typedef struct packed {
		logic       valid;
		logic [1:0] rotation;
		logic [1:0] click_kind;
	} res_t;

endpackage

/* hw/rtl/rec_core.sv */
module rec_core
	import rec_pkg::*;
#(
	parameter int TIME_WIDTH = TimeWidthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic        phase_a,
	input  logic        phase_b,
	input  logic        button_level,
	input  logic [15:0] debounce_ticks,
	input  logic [15:0] double_click_ticks,
	output res_t        res
);

	logic [TIME_WIDTH-1:0] tick_q;
	logic [TIME_WIDTH-1:0] last_change_q;
	logic [TIME_WIDTH-1:0] press_q;
	logic [1:0]            click_count_q;
	logic                  prev_button_q;
	logic                  prev_a_q;
	logic                  primed_q;

	logic [TIME_WIDTH-1:0] since_change;
	logic [TIME_WIDTH-1:0] since_press;
	logic [TIME_WIDTH-1:0] press_next;
	logic [1:0]            count_mid;
	logic [1:0]            count_next;
	logic                  changed;
	logic                  press;

	always_comb begin
		changed      = (button_level != prev_button_q);
		since_change = tick_q - last_change_q;
		press        = changed && !button_level &&
		               (since_change > TIME_WIDTH'(debounce_ticks));
		press_next   = press ? tick_q : press_q;
		count_mid    = click_count_q;
		if (press && click_count_q < ClickMax) begin
			count_mid = click_count_q + 2'd1;
		end
		since_press = tick_q - press_next;

		res.valid      = 1'b0;
		res.rotation   = ROT_NONE;
		res.click_kind = CLICK_NONE;
		count_next     = count_mid;

		if (phase_a && !prev_a_q) begin
			res.rotation = (phase_b != phase_a) ? ROT_CW : ROT_CCW;
		end
		priority if (count_mid >= ClickMax) begin
			res.click_kind = CLICK_DOUBLE;
			count_next     = 2'd0;
		end else if (count_mid == 2'd1 &&
		             since_press > TIME_WIDTH'(double_click_ticks)) begin
			res.click_kind = CLICK_SINGLE;
			count_next     = 2'd0;
		end
		// the first transaction only captures phase a
		res.valid = primed_q && (res.rotation != ROT_NONE || res.click_kind != CLICK_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q        <= '0;
			last_change_q <= '0;
			press_q       <= '0;
			click_count_q <= 2'd0;
			prev_button_q <= 1'b1;
			prev_a_q      <= 1'b0;
			primed_q      <= 1'b0;
		end else if (accept) begin
			tick_q   <= tick_q + TIME_WIDTH'(1);
			prev_a_q <= phase_a;
			primed_q <= 1'b1;
			if (primed_q) begin
				if (changed) begin
					last_change_q <= tick_q;
					prev_button_q <= button_level;
				end
				press_q       <= press_next;
				click_count_q <= count_next;
			end
		end
	end

endmodule

/* hw/rtl/rotary_encoder_click_detector.sv */
// Rotary encoder and push-button decoder. Each sample transaction carries one
// tick of encoder phases a and b and the active-low button; the block keeps a
// modular tick counter of TIME_WIDTH bits and reports a result transaction
// only when something happened: a rotation step on a rising edge of phase a
// (clockwise when b differs from a) and/or a single or double click derived
// from debounced presses. One sample is taken every cycle: the decode is a
// single pass of compares and two subtractions from the state registers into
// a result register, and a two-entry output buffer (result register plus skid)
// lets samples keep flowing while a result waits; sample_stall rises only when
// both entries are full. The first sample after reset only captures phase a.
// Registers on the APB port: 0x0 debounce_ticks (reset 50), 0x4
// double_click_ticks (reset 300), both 16 bits; write only while idle.
module rotary_encoder_click_detector
	import rec_pkg::*;
#(
	parameter int TIME_WIDTH = TimeWidthDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// sample channel
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic                 phase_a,
	input  logic                 phase_b,
	input  logic                 button_level,
	// result channel
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [1:0]           rotation,
	output logic [1:0]           click_kind,
	// configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	logic [15:0] debounce_q;
	logic [15:0] double_click_q;

	res_t res;
	logic accept;
	logic take;
	logic out_valid_q;
	logic skid_valid_q;
	logic [1:0] out_rot_q, out_click_q;
	logic [1:0] skid_rot_q, skid_click_q;

	// apb register file
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q     <= DebounceReset;
			double_click_q <= DoubleClickReset;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_DEBOUNCE:     debounce_q     <= pwdata[15:0];
				REG_DOUBLE_CLICK: double_click_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DEBOUNCE:     prdata = {16'd0, debounce_q};
			REG_DOUBLE_CLICK: prdata = {16'd0, double_click_q};
			default:          prdata = '0;
		endcase
	end

	// sample transactions are taken unless the skid entry is occupied
	assign sample_stall = skid_valid_q;
	assign accept       = sample_valid && !sample_stall;

	rec_core #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.accept            (accept),
		.phase_a           (phase_a),
		.phase_b           (phase_b),
		.button_level      (button_level),
		.debounce_ticks    (debounce_q),
		.double_click_ticks(double_click_q),
		.res               (res)
	);

	// output register and skid entry
	assign take = out_valid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
			if (accept && res.valid) begin
				// new result lands in the output register when it is free
				if (!out_valid_q || take) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && skid_valid_q) begin
			out_rot_q   <= skid_rot_q;
			out_click_q <= skid_click_q;
		end
		if (accept && res.valid) begin
			if (!out_valid_q || take) begin
				out_rot_q   <= res.rotation;
				out_click_q <= res.click_kind;
			end else begin
				skid_rot_q   <= res.rotation;
				skid_click_q <= res.click_kind;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign rotation     = out_rot_q;
	assign click_kind   = out_click_q;

endmodule

/* hw/rtl/rec_checker.sv */
module rec_checker
	import rec_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       sample_stall,
	input logic       result_valid,
	input logic       result_stall,
	input logic [1:0] rotation,
	input logic [1:0] click_kind
);

	// a held result stays valid
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result valid dropped while stalled");

	// a held result keeps its payload
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(rotation) && $stable(click_kind))
		else $error("result payload changed while stalled");

	// backpressure only when a result is already waiting
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid)
		else $error("sample stall without pending result");

	// a result always reports something
	a_result_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (rotation != ROT_NONE || click_kind != CLICK_NONE))
		else $error("empty result transaction");

	// only defined codes leave the block
	a_codes_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (rotation != 2'd3 && click_kind != 2'd3))
		else $error("undefined result code");

endmodule

bind rotary_encoder_click_detector rec_checker u_rec_checker (.*);
